>>> rtl/rpkv_pkg.sv
// ----------------------------------------------------------------------------
// rpkv_pkg
// Shared constants, opcodes and controller/datapath bundles for the
// rehashing open-addressing key-value map.
// ----------------------------------------------------------------------------
package rpkv_pkg;

    // field widths fixed by the interface
    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int CAP_W = 7;

    // default table size (must be a power of two)
    localparam int TABLE_SIZE_DEF = 64;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // operation codes
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // result status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_we;      // clear one slot during the reset sweep
        logic accept;      // capture the incoming transaction
        logic hash_start;  // start hashing the current probe
        logic probe_inc;   // move on to the next probe
        logic ins;         // insert a new entry at the probed slot
        logic upd;         // update the value of the matched entry
        logic res_set;     // capture the pending result
        logic res_fail;    // pending result is a failure
        logic res_hit;     // pending result carries the found value
        logic out_load;    // move the pending result to the output register
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;    // sweep is at the last slot
        logic opcode;      // opcode of the transaction in progress
        logic probe_ok;    // probe count still below its limit
        logic hash_done;   // hash of the current probe is ready
        logic hash_busy;   // hash unit is mixing
        logic slot_valid;  // probed slot holds an entry
        logic full;        // entry count has reached the capacity
        logic key_match;   // entry key equals the transaction key
    } dp_sts_t;

endpackage

>>> rtl/rpkv_ifs.sv
// ----------------------------------------------------------------------------
// rpkv_ifs
// Valid/ready channel interfaces for requests and responses of the map.
// ----------------------------------------------------------------------------
interface rpkv_req_if;
    import rpkv_pkg::*;

    logic             valid;
    logic             ready;
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, output opcode, output key, output value, input ready);
    modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface rpkv_rsp_if;
    import rpkv_pkg::*;

    logic             valid;
    logic             ready;
    logic             status;
    logic [VAL_W-1:0] found_value;

    modport source (output valid, output status, output found_value, input ready);
    modport sink   (input valid, input status, input found_value, output ready);
endinterface

>>> rtl/rehash_probe_key_value_map.sv
// ----------------------------------------------------------------------------
// rehash_probe_key_value_map
// Open-addressing key-value map; every probe rehashes key and probe number
// with lookup3 and masks the hash to a slot.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    opcode, key, value
//   rsp      out  valid/ready    status, found_value
//   cfg      in   cfg_wr_en      cfg_wr_data (capacity)
//
// each probe runs check, the one-step-per-cycle hash unit, slot memory read
// and entry memory read; a transaction ends at an empty slot, at a key match
// or when the probes run out; after reset a clear sweep runs over all
// TABLE_SIZE slots with req.ready low; the result waits in an output register,
// so a stalled rsp only holds off the next result, not the next request
// ----------------------------------------------------------------------------
module rehash_probe_key_value_map #(
    parameter int TABLE_SIZE = rpkv_pkg::TABLE_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rpkv_pkg::CAP_W-1:0] cfg_wr_data,
    rpkv_req_if.sink                   req,
    rpkv_rsp_if.source                 rsp
);
    import rpkv_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    rpkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and hashing
    rpkv_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req_opcode      (req.opcode),
        .req_key         (req.key),
        .req_value       (req.value),
        .cmd             (cmd),
        .sts             (sts),
        .rsp_status      (rsp.status),
        .rsp_found_value (rsp.found_value)
    );

    // one transaction in flight: ready drops after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in progress");

    // a new entry only goes into an empty slot below capacity
    a_insert_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> (!sts.full && !sts.slot_valid && sts.opcode == OP_STORE))
        else $error("insert into occupied slot or full table");

    // an update only follows a key match on a valid slot
    a_update_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> (sts.key_match && sts.slot_valid))
        else $error("value update without matching key");

    // hash is never restarted while mixing
    a_hash_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hash_start |-> !sts.hash_busy)
        else $error("hash started while busy");

endmodule

>>> rtl/rpkv_hash.sv
// ----------------------------------------------------------------------------
// rpkv_hash
// Iterative lookup3 final mix over a 12-byte message (key, probe), initial
// value 0. One mix step per cycle, seven steps per hash.
// ----------------------------------------------------------------------------
module rpkv_hash (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rpkv_pkg::KEY_W-1:0] key,
    input  logic [31:0]                probe,
    output logic                       busy,
    output logic                       done,
    output logic [31:0]                hash
);
    import rpkv_pkg::*;

    localparam logic [31:0] HASH_INIT = 32'hdeadbeef + 32'd12;
    localparam logic [2:0]  LAST_STEP = 3'd6;

    logic [31:0] a_reg, b_reg, c_reg;
    logic [31:0] a_next, b_next, c_next;
    logic [2:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
        rotl32 = (x << k) | (x >> (32 - k));
    endfunction

    // one mix step, selected by the step counter
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        case (step_reg)
            3'd0: c_next = (c_reg ^ b_reg) - rotl32(b_reg, 14);
            3'd1: a_next = (a_reg ^ c_reg) - rotl32(c_reg, 11);
            3'd2: b_next = (b_reg ^ a_reg) - rotl32(a_reg, 25);
            3'd3: c_next = (c_reg ^ b_reg) - rotl32(b_reg, 16);
            3'd4: a_next = (a_reg ^ c_reg) - rotl32(c_reg, 4);
            3'd5: b_next = (b_reg ^ a_reg) - rotl32(a_reg, 14);
            3'd6: c_next = (c_reg ^ b_reg) - rotl32(b_reg, 24);
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    // mixing state
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= HASH_INIT + key[31:0];
            b_reg <= HASH_INIT + key[KEY_W-1:32];
            c_reg <= HASH_INIT + probe;
        end
        else if (busy_reg)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    // step counter and handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign hash = c_reg;

endmodule

>>> rtl/rpkv_dp.sv
// ----------------------------------------------------------------------------
// rpkv_dp
// Datapath: capacity register, transaction registers, probe counter, hash
// unit, slot memory, entry key/value memories and result registers.
// ----------------------------------------------------------------------------
module rpkv_dp #(
    parameter int TABLE_SIZE = rpkv_pkg::TABLE_SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rpkv_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                       req_opcode,
    input  logic [rpkv_pkg::KEY_W-1:0] req_key,
    input  logic [rpkv_pkg::VAL_W-1:0] req_value,
    input  rpkv_pkg::dp_cmd_t          cmd,
    output rpkv_pkg::dp_sts_t          sts,
    output logic                       rsp_status,
    output logic [rpkv_pkg::VAL_W-1:0] rsp_found_value
);
    import rpkv_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int EW     = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    logic [CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  entry_count_reg;
    logic [SLOT_W-1:0] clr_cnt_reg;
    logic [CNT_W-1:0]  probe_reg;
    logic              opcode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;

    logic [SLOT_W:0]   slot_mem [TABLE_SIZE];
    logic [KEY_W-1:0]  key_mem  [TABLE_SIZE];
    logic [VAL_W-1:0]  val_mem  [TABLE_SIZE];
    logic [SLOT_W:0]   slot_q_reg;
    logic [KEY_W-1:0]  key_q_reg;
    logic [VAL_W-1:0]  val_q_reg;

    logic              pend_status_reg;
    logic [VAL_W-1:0]  pend_found_reg;
    logic              out_status_reg;
    logic [VAL_W-1:0]  out_found_reg;

    logic              hash_busy;
    logic              hash_done;
    logic [31:0]       hash;
    logic [SLOT_W-1:0] slot_addr;
    logic [SLOT_W-1:0] entry_idx;
    logic [EW-1:0]     cap_wide;
    logic [EW-1:0]     size_wide;
    logic [EW-1:0]     eff_wide;
    logic [CNT_W-1:0]  eff_cap;
    logic [CNT_W-1:0]  probe_limit;
    logic [SLOT_W-1:0] slot_wr_addr;
    logic [SLOT_W:0]   slot_wr_data;
    logic [SLOT_W-1:0] val_wr_addr;

    // capacity saturates at the table size
    assign cap_wide    = EW'(capacity_reg);
    assign size_wide   = EW'(TABLE_SIZE);
    assign eff_wide    = (cap_wide > size_wide) ? size_wide : cap_wide;
    assign eff_cap     = eff_wide[CNT_W-1:0];
    assign probe_limit = (opcode_reg == OP_LOOKUP) ? entry_count_reg : eff_cap;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // entry count and clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            clr_cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.ins)
            begin
                entry_count_reg <= entry_count_reg + CNT_W'(1);
            end
            if (cmd.clr_we)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
        end
    end

    // transaction and probe registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            opcode_reg <= req_opcode;
            key_reg    <= req_key;
            value_reg  <= req_value;
            probe_reg  <= '0;
        end
        else if (cmd.probe_inc)
        begin
            probe_reg <= probe_reg + CNT_W'(1);
        end
    end

    // per-probe hash
    rpkv_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.hash_start),
        .key   (key_reg),
        .probe (32'(probe_reg)),
        .busy  (hash_busy),
        .done  (hash_done),
        .hash  (hash)
    );

    assign slot_addr = hash[SLOT_W-1:0];
    assign entry_idx = slot_q_reg[SLOT_W-1:0];

    // slot memory: sweep clears, insert marks valid with the entry index
    assign slot_wr_addr = cmd.clr_we ? clr_cnt_reg : slot_addr;
    assign slot_wr_data = cmd.clr_we ? '0 : {1'b1, entry_count_reg[SLOT_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.clr_we || cmd.ins)
        begin
            slot_mem[slot_wr_addr] <= slot_wr_data;
        end
        slot_q_reg <= slot_mem[slot_addr];
    end

    // entry memories: insert at the fill point, update at the matched entry
    assign val_wr_addr = cmd.ins ? entry_count_reg[SLOT_W-1:0] : entry_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.ins)
        begin
            key_mem[entry_count_reg[SLOT_W-1:0]] <= key_reg;
        end
        if (cmd.ins || cmd.upd)
        begin
            val_mem[val_wr_addr] <= value_reg;
        end
        key_q_reg <= key_mem[entry_idx];
        val_q_reg <= val_mem[entry_idx];
    end

    // pending result and output register
    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            pend_status_reg <= cmd.res_fail ? ST_FAIL : ST_OK;
            pend_found_reg  <= cmd.res_hit ? val_q_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_found_reg  <= pend_found_reg;
        end
    end

    assign rsp_status      = out_status_reg;
    assign rsp_found_value = out_found_reg;

    // status to the controller
    always_comb
    begin
        sts.clr_last   = (clr_cnt_reg == SLOT_W'(TABLE_SIZE - 1));
        sts.opcode     = opcode_reg;
        sts.probe_ok   = (probe_reg < probe_limit);
        sts.hash_done  = hash_done;
        sts.hash_busy  = hash_busy;
        sts.slot_valid = slot_q_reg[SLOT_W];
        sts.full       = (entry_count_reg >= eff_cap);
        sts.key_match  = (key_q_reg == key_reg);
    end

endmodule

>>> rtl/rpkv_ctrl.sv
// ----------------------------------------------------------------------------
// rpkv_ctrl
// Controller: clear sweep after reset, then one transaction at a time
// through check, hash, slot read and entry compare per probe.
// ----------------------------------------------------------------------------
module rpkv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  rpkv_pkg::dp_sts_t    sts,
    output rpkv_pkg::dp_cmd_t    cmd
);
    import rpkv_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_CHECK  = 7'b0000100,
        S_HASH   = 7'b0001000,
        S_SLOT   = 7'b0010000,
        S_ENTRY  = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.probe_ok)
                begin
                    cmd.hash_start = 1'b1;
                    state_next     = S_HASH;
                end
                else
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_fail = 1'b1;
                    state_next   = S_RESULT;
                end
            end
            S_HASH:
            begin
                if (sts.hash_done)
                begin
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                if (sts.slot_valid)
                begin
                    state_next = S_ENTRY;
                end
                else
                begin
                    // empty slot ends the probe sequence
                    cmd.res_set = 1'b1;
                    if (sts.opcode == OP_STORE && !sts.full)
                    begin
                        cmd.ins = 1'b1;
                    end
                    else
                    begin
                        cmd.res_fail = 1'b1;
                    end
                    state_next = S_RESULT;
                end
            end
            S_ENTRY:
            begin
                if (sts.key_match)
                begin
                    cmd.res_set = 1'b1;
                    if (sts.opcode == OP_STORE)
                    begin
                        cmd.upd = 1'b1;
                    end
                    else
                    begin
                        cmd.res_hit = 1'b1;
                    end
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.probe_inc = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // output valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule
